### rtl/core/tcce_pkg.sv
// Package for the text console cursor engine: beat structs, operation and
// character codes, register indexes and default geometry. No dependencies.
package tcce_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int CELL_W    = 16;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 4;
   localparam int FUNC_W    = 2;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam int TAB_STEP = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'd1;

   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [CHAR_W-1:0]    char_code;
      logic [ROW_OUT_W-1:0] read_row;
      logic [COL_OUT_W-1:0] read_column;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_value;
      logic [ROW_OUT_W-1:0] cursor_row_out;
      logic [COL_OUT_W-1:0] cursor_column_out;
   } rsp_type;

endpackage

### rtl/core/text_console_cursor_engine.sv
// Text console cursor engine: screen cell memory, cursor, scroll and clear
// sequencer. Depends on tcce_pkg.
//
// The block holds a ROWS x COLUMNS screen of 16-bit cells (attribute byte
// high, character low) in one synchronous memory with a single write port
// and a registered read port, plus a cursor. Each request beat gives exactly
// one response beat carrying the read cell (zero unless a read hits the
// screen) and the cursor after the operation. A put that does not scroll, a
// read or an unused code goes to the finish state. A put that runs past the
// last row scrolls: each row below the top is copied one row up, the drain
// state ends the copy and the last row is blanked. A clear blanks every cell.
// Both passes use the one write port of the cell memory, which moves one cell
// a cycle. A new request is taken whenever the engine is idle, even while the
// previous response beat still waits in the output register. Colours must be
// written through the CSR port only while idle; the block does not enforce
// this. They apply to cells written afterwards. Cells never written since
// reset read back as unknown; there is no clearing pass after reset.
module text_console_cursor_engine #(
   parameter int COLUMNS = tcce_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcce_pkg::DEFAULT_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tcce_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tcce_pkg::rsp_type                   rsp_data,
   // register write port
   input  logic                                csr_write_en,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]        csr_wdata
);
   import tcce_pkg::*;

   localparam int TOTAL  = ROWS * COLUMNS;
   localparam int MOVED  = (ROWS - 1) * COLUMNS;   // cells shifted up by a scroll
   localparam int AW     = $clog2(TOTAL);
   localparam int CW     = $clog2(COLUMNS);
   localparam int RW     = $clog2(ROWS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL,   // read row below, write back from the read register
      ST_DRAIN,    // last copy write-back
      ST_FILL,     // blank cells from cnt to the end
      ST_FINISH    // hand the response to the output register
   } state_type;

   state_type            state_ff;
   logic [RW-1:0]        row_ff;
   logic [CW-1:0]        col_ff;
   logic [AW-1:0]        cnt_ff;
   logic                 wb_valid_ff;
   logic [AW-1:0]        wb_addr_ff;
   logic                 rd_sel_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic [COLOR_W-1:0]   fg_ff;
   logic [COLOR_W-1:0]   bg_ff;

   // cell memory
   logic [CELL_W-1:0]    screen_mem [TOTAL];
   logic [CELL_W-1:0]    rd_data_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;

   // put decode
   logic [RW-1:0]        row_in;
   logic [CW-1:0]        col_in;
   logic                 scroll_in;
   logic                 put_we;
   logic                 put_blank;
   logic [CW-1:0]        put_col;
   logic [CW:0]          col_x;
   logic [CW:0]          col_nx;
   logic [RW:0]          row_nx;

   logic                 accept;
   logic                 rsp_load;
   logic                 rd_ok;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        put_addr;
   logic [CHAR_W-1:0]    attr;
   logic [CELL_W-1:0]    blank_cell;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // output register takes a new beat when empty or emptying this cycle
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign attr       = {bg_ff, fg_ff};
   assign blank_cell = {attr, CH_SPACE};

   // colour registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FOREGROUND_RESET;
         bg_ff <= BACKGROUND_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FOREGROUND: fg_ff <= csr_wdata;
            CSR_BACKGROUND: bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cursor movement for a put
   always_comb begin
      col_x     = {1'b0, col_ff};
      col_nx    = col_x;
      row_nx    = {1'b0, row_ff};
      put_we    = 1'b0;
      put_blank = 1'b0;
      put_col   = col_ff;
      case (req_data.char_code)
         CH_NEWLINE: begin
            col_nx = '0;
            row_nx = row_nx + (RW+1)'(1);
         end
         CH_RETURN: col_nx = '0;
         CH_BACKSPACE: begin
            if (col_ff != '0) begin
               col_nx    = col_x - (CW+1)'(1);
               put_col   = col_ff - CW'(1);
               put_we    = 1'b1;
               put_blank = 1'b1;
            end
         end
         CH_TAB: col_nx = (col_x + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
         default: begin
            put_we = 1'b1;
            col_nx = col_x + (CW+1)'(1);
         end
      endcase
      // wrap at the right edge
      if (col_nx >= (CW+1)'(COLUMNS)) begin
         col_nx = '0;
         row_nx = row_nx + (RW+1)'(1);
      end
      scroll_in = (row_nx >= (RW+1)'(ROWS));
      row_in    = scroll_in ? RW'(ROWS - 1) : row_nx[RW-1:0];
      col_in    = col_nx[CW-1:0];
   end

   assign rd_ok    = (int'(req_data.read_row) < ROWS) && (int'(req_data.read_column) < COLUMNS);
   assign rd_addr  = AW'(req_data.read_row) * AW'(COLUMNS) + AW'(req_data.read_column);
   assign put_addr = AW'(row_ff) * AW'(COLUMNS) + AW'(put_col);

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = blank_cell;
      mem_re    = 1'b0;
      mem_raddr = cnt_ff + AW'(COLUMNS);
      if (wb_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wb_addr_ff;
         mem_wdata = rd_data_ff;
      end else if (state_ff == ST_FILL) begin
         mem_we    = 1'b1;
      end else if (accept && req_data.func == FUNC_PUT && put_we) begin
         mem_we    = 1'b1;
         mem_waddr = put_addr;
         mem_wdata = put_blank ? blank_cell : {attr, req_data.char_code};
      end
      if (state_ff == ST_SCROLL) begin
         mem_re    = 1'b1;
      end else if (accept && req_data.func == FUNC_READ && rd_ok) begin
         mem_re    = 1'b1;
         mem_raddr = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         wb_valid_ff  <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rd_sel_ff <= (req_data.func == FUNC_READ) && rd_ok;
                  cnt_ff    <= '0;
                  state_ff  <= ST_FINISH;
                  case (req_data.func)
                     FUNC_PUT: begin
                        row_ff <= row_in;
                        col_ff <= col_in;
                        if (scroll_in) begin
                           state_ff <= ST_SCROLL;
                        end
                     end
                     FUNC_CLEAR: begin
                        row_ff   <= '0;
                        col_ff   <= '0;
                        state_ff <= ST_FILL;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCROLL: begin
               wb_valid_ff <= 1'b1;
               wb_addr_ff  <= cnt_ff;
               if (cnt_ff == AW'(MOVED - 1)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               wb_valid_ff <= 1'b0;
               cnt_ff      <= AW'(MOVED);
               state_ff    <= ST_FILL;
            end
            ST_FILL: begin
               if (cnt_ff == AW'(TOTAL - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_data_ff.cell_value        <= rd_sel_ff ? rd_data_ff : '0;
                  rsp_data_ff.cursor_row_out    <= ROW_OUT_W'(row_ff);
                  rsp_data_ff.cursor_column_out <= COL_OUT_W'(col_ff);
                  state_ff                      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // cursor always stays on screen
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < (CW+1)'(COLUMNS))
      else $error("cursor column off screen");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < (RW+1)'(ROWS))
      else $error("cursor row off screen");

   // a copy write-back never survives into idle or the blanking pass
   a_wb_scope: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_SCROLL || state_ff == ST_DRAIN))
      else $error("stray scroll write-back");

   // every accepted beat takes the engine out of idle in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("engine idle right after accept");

   // blanking never runs past the last cell
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (cnt_ff <= AW'(TOTAL - 1)))
      else $error("fill pointer past end of screen");

endmodule
